// File: sv/lfu_cache_policy_core_defines.svh
// Assertion macros used by the bound checker file.
`ifndef LFU_CACHE_POLICY_CORE_DEFINES_SVH
`define LFU_CACHE_POLICY_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lfu assertion failed");

// Next-cycle implication, disabled in reset.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lfu assertion failed");

`endif

// File: sv/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

    localparam int KEY_W = 14;
    localparam int VAL_W = 31;
    localparam int CAP_W = 7;

    // keys at or above this bound are ignored
    localparam int KEY_SPACE = 16384;
    localparam int KEY_CMP_W = 17;

    localparam int SLOTS_DEF      = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

// File: sv/lfu_req_if.sv
`default_nettype none

interface lfu_req_if import lfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

`default_nettype wire

// File: sv/lfu_rsp_if.sv
`default_nettype none

interface lfu_rsp_if import lfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

// File: sv/lfu_cache_policy_core.sv
// Channel   Dir   Handshake      Payload
// i_req     in    valid/ready    opcode, key, value
// o_rsp     out   valid/ready    hit, read_value, evicted, evicted_key
// i_cfg     in    write enable   capacity (7 bits)
//
// An item runs one full pass over the slot memory (one read per cycle, registered
// read data), then a decide state and a result state; a put that evicts into a
// lower free slot adds an evict state that writes the new entry. Out-of-range keys
// and puts at capacity zero go straight to the result state.
// After reset a clearing pass over every slot invalidates the memory; i_req.ready
// stays low until it ends. The result sits in an output register, so the next
// item is taken while a result waits on o_rsp.ready.
`default_nettype none

module lfu_cache_policy_core import lfu_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    lfu_req_if.sink               i_req,
    lfu_rsp_if.source             o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EVICT  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_rd;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_idx;
    logic [CNT_W-1:0]      r_occ;
    logic [STAMP_BITS-1:0] r_clock;
    logic [CAP_W-1:0]      r_capacity;

    logic                  r_op;
    logic [KEY_W-1:0]      r_key;
    logic [VAL_W-1:0]      r_val;

    logic                  r_match_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic [VAL_W-1:0]      r_match_val;
    logic [COUNT_BITS-1:0] r_match_cnt;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_vic_found;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [KEY_W-1:0]      r_vic_key;
    logic [COUNT_BITS-1:0] r_vic_cnt;
    logic [STAMP_BITS-1:0] r_vic_age;

    logic                  r_res_hit;
    logic [VAL_W-1:0]      r_res_rv;
    logic                  r_res_ev;
    logic [KEY_W-1:0]      r_res_ek;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [VAL_W-1:0]      r_out_rv;
    logic                  r_out_ev;
    logic [KEY_W-1:0]      r_out_ek;

    logic                  w_we;
    logic [IDX_W-1:0]      w_addr;
    t_entry                w_data;

    logic                  accept;
    logic                  skip;
    logic                  scan_done;
    logic                  full;
    logic                  split;
    logic                  fin_go;
    logic                  better;
    logic [STAMP_BITS-1:0] age;
    logic [COUNT_BITS-1:0] cnt_inc;
    t_entry                ins_entry;
    t_entry                upd_entry;

    assign accept    = i_req.valid && (r_state == S_IDLE);
    assign skip      = ({{(KEY_CMP_W-KEY_W){1'b0}}, i_req.key} >= KEY_CMP_W'(KEY_SPACE))
                    || (i_req.opcode == OP_PUT && r_capacity == '0);
    assign scan_done = (r_rd == CNT_W'(SLOTS)) && !r_pend;
    // occupancy >= min(capacity, SLOTS)
    assign full      = (CMP_W'(r_occ) >= CMP_W'(r_capacity)) || (r_occ >= CNT_W'(SLOTS));
    assign split     = full && r_free_found && (r_free_idx < r_vic_idx);
    assign fin_go    = !r_out_valid || o_rsp.ready;

    assign age    = r_clock - r_rd_data.stamp;
    assign better = !r_vic_found || (r_rd_data.count < r_vic_cnt)
                 || ((r_rd_data.count == r_vic_cnt) && (age > r_vic_age));

    assign cnt_inc = (&r_match_cnt) ? r_match_cnt : r_match_cnt + 1'b1;

    always_comb begin
        ins_entry       = '0;
        ins_entry.valid = 1'b1;
        ins_entry.key   = r_key;
        ins_entry.value = r_val;
        ins_entry.count = COUNT_BITS'(1);
        ins_entry.stamp = r_clock;

        upd_entry       = ins_entry;
        upd_entry.value = (r_op == OP_PUT) ? r_val : r_match_val;
        upd_entry.count = cnt_inc;
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_addr  = r_rd[IDX_W-1:0];
        w_data  = '0;
        unique case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                if (r_rd == CNT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = skip ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                if (r_match_found) begin
                    w_we   = 1'b1;
                    w_addr = r_match_idx;
                    w_data = upd_entry;
                end else if (r_op == OP_PUT) begin
                    w_we = 1'b1;
                    if (split) begin
                        // drop the victim now, insert into the lower free slot next
                        w_addr  = r_vic_idx;
                        n_state = S_EVICT;
                    end else begin
                        w_addr = full ? r_vic_idx : r_free_idx;
                        w_data = ins_entry;
                    end
                end
            end
            S_EVICT: begin
                w_we    = 1'b1;
                w_addr  = r_free_idx;
                w_data  = ins_entry;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_rd[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_rd        <= '0;
            r_pend      <= 1'b0;
            r_occ       <= '0;
            r_clock     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end

            if (r_state == S_FIN && fin_go) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= r_res_hit;
                r_out_rv    <= r_res_rv;
                r_out_ev    <= r_res_ev;
                r_out_ek    <= r_res_ek;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_rd <= (r_rd == CNT_W'(SLOTS - 1)) ? '0 : r_rd + 1'b1;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op          <= i_req.opcode;
                        r_key         <= i_req.key;
                        r_val         <= i_req.value;
                        r_rd          <= '0;
                        r_pend        <= 1'b0;
                        r_match_found <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_vic_found   <= 1'b0;
                        r_res_hit     <= 1'b0;
                        r_res_rv      <= '0;
                        r_res_ev      <= 1'b0;
                        r_res_ek      <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_rd != CNT_W'(SLOTS)) begin
                        r_rd       <= r_rd + 1'b1;
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd[IDX_W-1:0];
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (r_rd_data.valid) begin
                            if (!r_match_found && r_rd_data.key == r_key) begin
                                r_match_found <= 1'b1;
                                r_match_idx   <= r_pend_idx;
                                r_match_val   <= r_rd_data.value;
                                r_match_cnt   <= r_rd_data.count;
                            end
                            if (better) begin
                                r_vic_found <= 1'b1;
                                r_vic_idx   <= r_pend_idx;
                                r_vic_key   <= r_rd_data.key;
                                r_vic_cnt   <= r_rd_data.count;
                                r_vic_age   <= age;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pend_idx;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_match_found) begin
                        r_clock   <= r_clock + 1'b1;
                        r_res_hit <= 1'b1;
                        r_res_rv  <= (r_op == OP_GET) ? r_match_val : '0;
                    end else if (r_op == OP_PUT) begin
                        if (!split) begin
                            r_clock <= r_clock + 1'b1;
                        end
                        if (full) begin
                            r_res_ev <= 1'b1;
                            r_res_ek <= r_vic_key;
                        end else begin
                            r_occ <= r_occ + 1'b1;
                        end
                    end
                end
                S_EVICT: begin
                    r_clock <= r_clock + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_rv;
    assign o_rsp.evicted     = r_out_ev;
    assign o_rsp.evicted_key = r_out_ek;

endmodule

`default_nettype wire

// File: sv/lfu_cache_policy_core_chk.sv
`default_nettype none
`include "lfu_cache_policy_core_defines.svh"

module lfu_cache_policy_core_chk import lfu_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic             i_rsp_hit,
    input wire logic [VAL_W-1:0] i_rsp_read_value,
    input wire logic             i_rsp_evicted,
    input wire logic [KEY_W-1:0] i_rsp_evicted_key
);

    // hold a stalled result
    `LFU_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_read_value) && $stable(i_rsp_evicted) && $stable(i_rsp_evicted_key))

    // the clearing pass keeps the input closed right after reset
    `LFU_ASSERT_IMPL(a_clear_closed, i_clk, i_rst_n, $past(!i_rst_n), !i_req_ready)

    // one item at a time
    `LFU_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // an eviction only comes from a put miss
    `LFU_ASSERT_IMPL(a_evict_miss, i_clk, i_rst_n, i_rsp_valid && i_rsp_evicted, !i_rsp_hit && i_rsp_read_value == '0)

endmodule

bind lfu_cache_policy_core lfu_cache_policy_core_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_read_value  (o_rsp.read_value),
    .i_rsp_evicted     (o_rsp.evicted),
    .i_rsp_evicted_key (o_rsp.evicted_key)
);

`default_nettype wire

// File: sim/lfu_cache_policy_core_checker.sv
module lfu_cache_policy_core_checker import lfu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lfu_req_if               i_req,
    lfu_rsp_if               i_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = SLOTS_DEF;
    localparam int COUNT_W = COUNT_BITS_DEF;
    localparam int STAMP_W = STAMP_BITS_DEF;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_cache_result;

    logic               slot_valid [SLOTS];
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VAL_W-1:0]   slot_value [SLOTS];
    logic [COUNT_W-1:0] slot_count [SLOTS];
    logic [STAMP_W-1:0] slot_stamp [SLOTS];
    int                 occupancy;
    logic [STAMP_W-1:0] access_clock;
    logic [CAP_W-1:0]   capacity;

    t_cache_result expected_results [$];
    int            results_seen;

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key) return i;
        end
        return -1;
    endfunction

    // Count a use: saturate the count, restamp, advance the clock.
    function automatic void touch_slot(int s);
        if (slot_count[s] != '1) slot_count[s]++;
        slot_stamp[s] = access_clock;
        access_clock++;
    endfunction

    function automatic t_cache_result apply_cache_op(logic op, logic [KEY_W-1:0] key,
                                                     logic [VAL_W-1:0] value);
        t_cache_result      res;
        int                 eff_cap;
        int                 slot;
        int                 victim;
        int                 free_slot;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] best_age;
        logic [COUNT_W-1:0] best_count;
        res = '0;
        eff_cap = (capacity > SLOTS) ? SLOTS : int'(capacity);
        slot = find_key(key);
        if (op == OP_GET) begin
            if (slot >= 0) begin
                touch_slot(slot);
                res.hit = 1'b1;
                res.read_value = slot_value[slot];
            end
        end else if (eff_cap != 0) begin
            if (slot >= 0) begin
                touch_slot(slot);
                slot_value[slot] = value;
                res.hit = 1'b1;
            end else begin
                // Full (or over a lowered capacity): drop the least used,
                // oldest first among equal counts, lowest slot on a full tie.
                if (occupancy >= eff_cap) begin
                    victim = -1;
                    best_count = '0;
                    best_age = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i]) begin
                            age = access_clock - slot_stamp[i];
                            if (victim < 0 || slot_count[i] < best_count ||
                                (slot_count[i] == best_count && age > best_age)) begin
                                victim = i;
                                best_count = slot_count[i];
                                best_age = age;
                            end
                        end
                    end
                    if (victim >= 0) begin
                        slot_valid[victim] = 1'b0;
                        res.evicted = 1'b1;
                        res.evicted_key = slot_key[victim];
                        if (occupancy > 0) occupancy--;
                    end
                end
                free_slot = 0;
                while (free_slot < SLOTS && slot_valid[free_slot]) free_slot++;
                if (free_slot < SLOTS) begin
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot] = key;
                    slot_value[free_slot] = value;
                    slot_count[free_slot] = 1;
                    slot_stamp[free_slot] = access_clock;
                    access_clock++;
                    occupancy++;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint unsigned expv, longint unsigned gotv);
        $display("%t: result %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, results_seen, field, expv, gotv);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_cache_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_count[i] = '0;
                slot_stamp[i] = '0;
            end
            occupancy = 0;
            access_clock = '0;
            capacity = CAP_RESET;
            expected_results.delete();
            results_seen = 0;
            o_fail_count = 0;
        end else begin
            // A result leaving this cycle belongs to an older item.
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 1);
                end else begin
                    exp_res = expected_results[0];
                    expected_results.delete(0);
                    if (i_rsp.hit !== exp_res.hit)
                        report_mismatch("hit", exp_res.hit, i_rsp.hit);
                    if (i_rsp.read_value !== exp_res.read_value)
                        report_mismatch("read_value", exp_res.read_value, i_rsp.read_value);
                    if (i_rsp.evicted !== exp_res.evicted)
                        report_mismatch("evicted", exp_res.evicted, i_rsp.evicted);
                    if (i_rsp.evicted_key !== exp_res.evicted_key)
                        report_mismatch("evicted_key", exp_res.evicted_key, i_rsp.evicted_key);
                end
                results_seen++;
            end
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_req.valid && i_req.ready)
                expected_results.insert(expected_results.size(),
                                        apply_cache_op(i_req.opcode, i_req.key,
                                                       i_req.value));
        end
        o_pending = expected_results.size();
    end

endmodule

// File: sim/lfu_cache_policy_core_tb.sv
module lfu_cache_policy_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int ITEM_LATENCY   = SLOTS_DEF + 8;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 150;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lfu_req_if req ();
    lfu_rsp_if rsp ();

    int               fail_count;
    int               pending_results;
    int               idle_cycles = 0;
    bit               calm;
    bit               hold_request;
    logic [KEY_W-1:0] key_pool [$];

    always #5ns i_clk = ~i_clk;

    lfu_cache_policy_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    lfu_cache_policy_core_checker cache_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // Mostly short gaps, now and then a long one; none while calm.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no item moved for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp.ready <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                rsp.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    rsp.ready <= 1'b0;
                    stall_left--;
                end else begin
                    rsp.ready <= 1'b1;
                end
            end
        end
    end

    // Offer one item and return at the falling edge after it is taken.
    task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.key <= key;
        req.value <= value;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drain();
        // let a trailing slot write finish before touching the register
        repeat (ITEM_LATENCY) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Skew picks toward the front of the key pool so counts spread out;
    // a few keys are drawn from the whole key range.
    task automatic run_random_phase(int n_items, int pool_target);
        int               pick;
        logic [KEY_W-1:0] key;
        while (key_pool.size() < pool_target)
            key_pool.insert(key_pool.size(), KEY_W'($urandom));
        while (key_pool.size() > pool_target)
            key_pool.delete($urandom_range(0, key_pool.size() - 1));
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < 8) begin
                key = KEY_W'($urandom);
            end else begin
                pick = $urandom_range(0, $urandom_range(0, key_pool.size() - 1));
                key = key_pool[pick];
            end
            send_item($urandom_range(0, 1) ? OP_PUT : OP_GET, key, VAL_W'($urandom));
        end
    endtask

    initial begin
        int caps [11];
        int eff_cap;
        caps = '{64, 3, 127, 1, 0, 17, 64, 2, 100, 8, 0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req.valid = 1'b0;
        req.opcode = OP_GET;
        req.key = '0;
        req.value = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two entries: recency tie-break, then count order, put hit.
        set_capacity(7'd2);
        send_item(OP_GET, 14'h0000, 31'h0);
        send_item(OP_PUT, 14'h0000, 31'h0);
        send_item(OP_PUT, 14'h3FFF, 31'h7FFF_FFFF);
        send_item(OP_PUT, 14'h2AAA, 31'h2AAA_AAAA);
        send_item(OP_GET, 14'h3FFF, 31'h0);
        send_item(OP_PUT, 14'h1555, 31'h5555_5555);
        send_item(OP_PUT, 14'h1555, 31'h1);
        send_item(OP_GET, 14'h1555, 31'h7FFF_FFFF);
        send_item(OP_PUT, 14'h0001, 31'h1234_5678);
        // Capacity below occupancy: one eviction per new key.
        set_capacity(7'd1);
        send_item(OP_PUT, 14'h0002, 31'h0);
        send_item(OP_GET, 14'h1555, 31'h0);
        // Zero capacity: puts do nothing, gets still look up.
        set_capacity(7'd0);
        send_item(OP_PUT, 14'h0003, 31'h7FFF_FFFF);
        send_item(OP_PUT, 14'h1555, 31'h0);
        send_item(OP_GET, 14'h1555, 31'h0);
        send_item(OP_GET, 14'h0004, 31'h0);
        // Above the slot count: saturates.
        set_capacity(7'd127);
        send_item(OP_PUT, 14'h3FFE, 31'h7FFF_FFFE);
        send_item(OP_GET, 14'h3FFE, 31'h0);

        caps[10] = $urandom_range(0, 127);
        foreach (caps[p]) begin
            set_capacity(CAP_W'(caps[p]));
            calm = (p == 5);
            // hold results off while items keep coming
            if (p == 2) hold_request = 1'b1;
            eff_cap = (caps[p] > SLOTS_DEF) ? SLOTS_DEF : caps[p];
            run_random_phase(PHASE_ITEMS, eff_cap + $urandom_range(2, 8));
        end
        calm = 1'b0;

        wait_drain();
        repeat (ITEM_LATENCY) @(negedge i_clk);
        if (pending_results != 0)
            $display("%0d results never arrived", pending_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: lfu_cache_policy_core.f
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_cache_policy_core.sv
sv/lfu_cache_policy_core_chk.sv
sim/lfu_cache_policy_core_checker.sv
sim/lfu_cache_policy_core_tb.sv
